/* hw/rtl/mpsl_pkg.sv */
package mpsl_pkg;

    localparam int CoordW   = 32;
    localparam int DiffW    = 33;
    localparam int NormW    = 20;
    localparam int NormPad  = 19;
    localparam int BlenW    = 6;
    localparam int SqW      = 40;
    localparam int S2W      = 42;
    localparam int LookW    = 31;
    localparam int PrW      = 52;
    localparam int DotW     = 54;
    localparam int NhW      = 52;
    localparam int RrW      = 21;
    localparam int R3W      = 63;
    localparam int R3Shift  = 24;
    localparam int DvsrW    = 39;
    localparam int FracShift = 11;
    localparam int NumW     = 63;
    localparam int QW       = 30;
    localparam int RateW    = 32;
    localparam int NuW      = 16;
    localparam int RnW      = 49;
    localparam int PW       = 81;
    localparam int ProdW    = 111;
    localparam int ShW      = 76;
    localparam int TW       = 7;
    localparam int TBase    = 33;
    localparam int CfgIdxW  = 3;

    // round(2^8 * seconds per year / pi)
    localparam logic [31:0] Ypi = 32'd2571544592;

    localparam logic signed [LookW-1:0] LookA [3] =
        '{-31'sd661544442, -31'sd122610015, 31'sd836807768};
    localparam logic signed [LookW-1:0] LookB [3] =
        '{31'sd698412668, -31'sd128182712, 31'sd805425629};

    typedef logic [CfgIdxW-1:0] cfg_idx_t;

    localparam cfg_idx_t RegSourceEast  = 3'd0;
    localparam cfg_idx_t RegSourceNorth = 3'd1;
    localparam cfg_idx_t RegSourceDepth = 3'd2;
    localparam cfg_idx_t RegVolumeRate  = 3'd3;
    localparam cfg_idx_t RegPoisson     = 3'd4;
    localparam cfg_idx_t RegLookSelect  = 3'd5;

    typedef struct packed {
        logic             zero;
        logic [BlenW-1:0] blen;
        logic             nneg;
    } mpsl_side_t;

endpackage

/* hw/rtl/mpsl_norm.sv */
module mpsl_norm
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     en,
    input  logic                                     in_valid,
    input  logic signed [mpsl_pkg::CoordW-1:0]       obs_east,
    input  logic signed [mpsl_pkg::CoordW-1:0]       obs_north,
    input  logic signed [mpsl_pkg::CoordW-1:0]       source_east,
    input  logic signed [mpsl_pkg::CoordW-1:0]       source_north,
    input  logic signed [mpsl_pkg::CoordW-1:0]       source_depth,
    input  logic                                     look_select,
    output logic                                     out_valid,
    output logic [mpsl_pkg::S2W-1:0]                 out_s2,
    output logic [mpsl_pkg::NhW-1:0]                 out_nh,
    output mpsl_pkg::mpsl_side_t                     out_side
);

    localparam int DiffW = mpsl_pkg::DiffW;
    localparam int NormW = mpsl_pkg::NormW;
    localparam int BlenW = mpsl_pkg::BlenW;
    localparam int ExtW  = DiffW + mpsl_pkg::NormPad;

    logic [3:0] vld_reg;

    // stage 1: offsets
    logic signed [DiffW-1:0] d_next [3];
    logic [DiffW-1:0]        mag_next [3];
    logic [DiffW-1:0]        mag_reg [3];
    logic [2:0]              sgn1_reg;

    // stage 2: normalization
    logic [DiffW-1:0]        orv;
    logic [BlenW-1:0]        blen_next;
    logic [BlenW-1:0]        sh;
    logic [ExtW-1:0]         ext [3];
    logic [NormW-1:0]        m_next [3];
    logic [NormW-1:0]        m_reg [3];
    logic [2:0]              sgn2_reg;
    logic [BlenW-1:0]        blen2_reg;
    logic                    zero2_reg;

    // stage 3: squares and look products
    logic signed [NormW:0]                 sm [3];
    logic signed [mpsl_pkg::LookW-1:0]     lk [3];
    logic [mpsl_pkg::SqW-1:0]              sq_next [3];
    logic [mpsl_pkg::SqW-1:0]              sq_reg [3];
    logic signed [mpsl_pkg::PrW-1:0]       pr_next [3];
    logic signed [mpsl_pkg::PrW-1:0]       pr_reg [3];
    logic [BlenW-1:0]                      blen3_reg;
    logic                                  zero3_reg;

    // stage 4: sums
    logic [mpsl_pkg::S2W-1:0]              s2_next;
    logic signed [mpsl_pkg::DotW-1:0]      dot;
    logic [mpsl_pkg::DotW-1:0]             dabs;
    logic [mpsl_pkg::S2W-1:0]              s2_reg;
    logic [mpsl_pkg::NhW-1:0]              nh_reg;
    mpsl_pkg::mpsl_side_t                  side_reg;

    always_comb
    begin
        d_next[0] = DiffW'(obs_east) - DiffW'(source_east);
        d_next[1] = DiffW'(obs_north) - DiffW'(source_north);
        d_next[2] = DiffW'(source_depth);
        for (int i = 0; i < 3; i++)
        begin
            mag_next[i] = d_next[i][DiffW-1] ? DiffW'(-d_next[i]) : DiffW'(d_next[i]);
        end
    end

    // largest magnitude lands in [2^19, 2^20)
    always_comb
    begin
        orv = mag_reg[0] | mag_reg[1] | mag_reg[2];
        blen_next = '0;
        for (int i = 0; i < DiffW; i++)
        begin
            if (orv[i])
            begin
                blen_next = BlenW'(i + 1);
            end
        end
        sh = (blen_next == '0) ? '0 : blen_next - BlenW'(1);
        for (int i = 0; i < 3; i++)
        begin
            ext[i]    = {mag_reg[i], {mpsl_pkg::NormPad{1'b0}}} >> sh;
            m_next[i] = ext[i][NormW-1:0];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sm[i]      = sgn2_reg[i] ? -$signed({1'b0, m_reg[i]}) : $signed({1'b0, m_reg[i]});
            lk[i]      = look_select ? mpsl_pkg::LookA[i] : mpsl_pkg::LookB[i];
            sq_next[i] = mpsl_pkg::SqW'(m_reg[i]) * mpsl_pkg::SqW'(m_reg[i]);
            pr_next[i] = mpsl_pkg::PrW'(lk[i]) * mpsl_pkg::PrW'(sm[i]);
        end
    end

    always_comb
    begin
        s2_next = mpsl_pkg::S2W'(sq_reg[0]) + mpsl_pkg::S2W'(sq_reg[1])
                + mpsl_pkg::S2W'(sq_reg[2]);
        dot     = mpsl_pkg::DotW'(pr_reg[0]) + mpsl_pkg::DotW'(pr_reg[1])
                + mpsl_pkg::DotW'(pr_reg[2]);
        dabs    = dot[mpsl_pkg::DotW-1] ? mpsl_pkg::DotW'(-dot) : mpsl_pkg::DotW'(dot);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mag_reg[i]  <= mag_next[i];
                sgn1_reg[i] <= d_next[i][DiffW-1];
                m_reg[i]    <= m_next[i];
                sq_reg[i]   <= sq_next[i];
                pr_reg[i]   <= pr_next[i];
            end
            sgn2_reg       <= sgn1_reg;
            blen2_reg      <= blen_next;
            zero2_reg      <= (orv == '0);
            blen3_reg      <= blen2_reg;
            zero3_reg      <= zero2_reg;
            s2_reg         <= s2_next;
            nh_reg         <= dabs[mpsl_pkg::NhW-1:0];
            side_reg.zero  <= zero3_reg;
            side_reg.blen  <= blen3_reg;
            side_reg.nneg  <= dot[mpsl_pkg::DotW-1];
        end
    end

    assign out_valid = vld_reg[3];
    assign out_s2    = s2_reg;
    assign out_nh    = nh_reg;
    assign out_side  = side_reg;

endmodule

/* hw/rtl/mpsl_isqrt.sv */
module mpsl_isqrt
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [mpsl_pkg::S2W-1:0]      in_s2,
    input  logic [mpsl_pkg::NhW-1:0]      in_nh,
    input  mpsl_pkg::mpsl_side_t          in_side,
    output logic                          out_valid,
    output logic [mpsl_pkg::RrW-1:0]      out_root,
    output logic [mpsl_pkg::S2W-1:0]      out_s2,
    output logic [mpsl_pkg::NhW-1:0]      out_nh,
    output mpsl_pkg::mpsl_side_t          out_side
);

    localparam int N  = mpsl_pkg::RrW;
    localparam int VW = mpsl_pkg::S2W;
    localparam int TrW = VW + 1;

    logic [N-1:0]         vld_reg;
    logic [VW-1:0]        rem_reg  [N];
    logic [N-1:0]         root_reg [N];
    logic [VW-1:0]        s2_reg   [N];
    logic [mpsl_pkg::NhW-1:0] nh_reg [N];
    mpsl_pkg::mpsl_side_t side_reg [N];

    logic [VW-1:0]        rem_src   [N];
    logic [N-1:0]         root_src  [N];
    logic [TrW-1:0]       trial     [N];
    logic [VW-1:0]        rem_next  [N];
    logic [N-1:0]         root_next [N];

    // one root bit per stage, remainder kept as s2 - root^2
    always_comb
    begin
        rem_src[0]  = in_s2;
        root_src[0] = '0;
        for (int k = 1; k < N; k++)
        begin
            rem_src[k]  = rem_reg[k-1];
            root_src[k] = root_reg[k-1];
        end
        for (int k = 0; k < N; k++)
        begin
            trial[k] = (TrW'(root_src[k]) << (N - k)) + (TrW'(1) << (2 * (N - 1 - k)));
            if ({1'b0, rem_src[k]} >= trial[k])
            begin
                rem_next[k]  = rem_src[k] - trial[k][VW-1:0];
                root_next[k] = root_src[k] | (N'(1) << (N - 1 - k));
            end
            else
            begin
                rem_next[k]  = rem_src[k];
                root_next[k] = root_src[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[N-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_reg[0]   <= in_s2;
            nh_reg[0]   <= in_nh;
            side_reg[0] <= in_side;
            for (int k = 1; k < N; k++)
            begin
                s2_reg[k]   <= s2_reg[k-1];
                nh_reg[k]   <= nh_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
            for (int k = 0; k < N; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign out_root  = root_reg[N-1];
    assign out_s2    = s2_reg[N-1];
    assign out_nh    = nh_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

/* hw/rtl/mpsl_div.sv */
module mpsl_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [mpsl_pkg::NumW-1:0]     in_num,
    input  logic [mpsl_pkg::DvsrW-1:0]    in_dvsr,
    input  mpsl_pkg::mpsl_side_t          in_side,
    output logic                          out_valid,
    output logic [mpsl_pkg::QW-1:0]       out_quot,
    output mpsl_pkg::mpsl_side_t          out_side
);

    localparam int N   = mpsl_pkg::QW;
    localparam int RW  = mpsl_pkg::NumW;
    localparam int DW  = mpsl_pkg::DvsrW;
    localparam int CmW = DW + N - 1;

    logic [N-1:0]         vld_reg;
    logic [RW-1:0]        rem_reg  [N];
    logic [N-1:0]         quot_reg [N];
    logic [DW-1:0]        dvsr_reg [N];
    mpsl_pkg::mpsl_side_t side_reg [N];

    logic [RW-1:0]        rem_src   [N];
    logic [N-1:0]         quot_src  [N];
    logic [DW-1:0]        dvsr_src  [N];
    logic [CmW-1:0]       cand      [N];
    logic [RW-1:0]        rem_next  [N];
    logic [N-1:0]         quot_next [N];

    // restoring division, quotient MSB first
    always_comb
    begin
        rem_src[0]  = in_num;
        quot_src[0] = '0;
        dvsr_src[0] = in_dvsr;
        for (int k = 1; k < N; k++)
        begin
            rem_src[k]  = rem_reg[k-1];
            quot_src[k] = quot_reg[k-1];
            dvsr_src[k] = dvsr_reg[k-1];
        end
        for (int k = 0; k < N; k++)
        begin
            cand[k] = CmW'(dvsr_src[k]) << (N - 1 - k);
            if (CmW'(rem_src[k]) >= cand[k])
            begin
                rem_next[k]  = rem_src[k] - cand[k][RW-1:0];
                quot_next[k] = quot_src[k] | (N'(1) << (N - 1 - k));
            end
            else
            begin
                rem_next[k]  = rem_src[k];
                quot_next[k] = quot_src[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[N-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= in_side;
            for (int k = 1; k < N; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
            for (int k = 0; k < N; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                quot_reg[k] <= quot_next[k];
                dvsr_reg[k] <= dvsr_src[k];
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign out_quot  = quot_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

/* hw/rtl/mogi_point_source_los.sv */
// Mogi point source, line-of-sight displacement.
// One request per cycle is accepted while in_stall is low.
// Depth is set by the 21-stage square root and the 30-stage divider pipelines.
// A stall on the output freezes every data stage; nothing is dropped or repeated.
// Reset clears all valid bits and loads the register defaults.
module mogi_point_source_los
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [mpsl_pkg::CoordW-1:0]   obs_east,
    input  logic signed [mpsl_pkg::CoordW-1:0]   obs_north,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [31:0]                   los_displacement,
    output logic                                 out_of_range,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  mpsl_pkg::cfg_idx_t                   cfg_index,
    input  logic [31:0]                          cfg_data
);

    localparam int ProdW = mpsl_pkg::ProdW;
    localparam int ShW   = mpsl_pkg::ShW;

    logic signed [31:0]          src_east_reg;
    logic signed [31:0]          src_north_reg;
    logic signed [31:0]          src_depth_reg;
    logic signed [31:0]          rate_reg;
    logic [mpsl_pkg::NuW-1:0]    nu_reg;
    logic                        look_reg;

    logic adv;

    logic                          n_valid;
    logic [mpsl_pkg::S2W-1:0]      n_s2;
    logic [mpsl_pkg::NhW-1:0]      n_nh;
    mpsl_pkg::mpsl_side_t          n_side;

    logic                          q_valid;
    logic [mpsl_pkg::RrW-1:0]      q_root;
    logic [mpsl_pkg::S2W-1:0]      q_s2;
    logic [mpsl_pkg::NhW-1:0]      q_nh;
    mpsl_pkg::mpsl_side_t          q_side;

    logic                          r_valid_reg;
    logic [mpsl_pkg::R3W-1:0]      r3;
    logic [mpsl_pkg::DvsrW-1:0]    dvsr_reg;
    logic [mpsl_pkg::NumW-1:0]     num_reg;
    mpsl_pkg::mpsl_side_t          r_side_reg;

    logic                          d_valid;
    logic [mpsl_pkg::QW-1:0]       d_quot;
    mpsl_pkg::mpsl_side_t          d_side;

    // rate-dependent scale, follows the registers through rn_reg, pa_reg/pb_reg and p_reg
    logic [31:0]                   rmag;
    logic [mpsl_pkg::RnW-1:0]      rn_reg;
    logic [63:0]                   pa_reg;
    logic [mpsl_pkg::RnW-1:0]      pb_reg;
    logic [mpsl_pkg::PW-1:0]       p_reg;

    logic [2:0]                    f_valid_reg;
    logic [61:0]                   pp0_reg;
    logic [61:0]                   pp1_reg;
    logic [46:0]                   pp2_reg;
    logic [ProdW-1:0]              prod_reg;
    logic [ShW-1:0]                shv_reg;
    logic [mpsl_pkg::TW-1:0]       tsh;
    mpsl_pkg::mpsl_side_t          f_side_reg [3];

    logic                          neg;
    logic [ShW-1:0]                limit;
    logic                          sat;
    logic [31:0]                   res;
    logic                          out_valid_reg;
    logic [31:0]                   los_reg;
    logic                          oor_reg;

    assign adv       = !out_valid_reg || !out_stall;
    assign in_stall  = !adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_east_reg  <= '0;
            src_north_reg <= '0;
            src_depth_reg <= 32'sd4096;
            rate_reg      <= '0;
            nu_reg        <= 16'd16384;
            look_reg      <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                mpsl_pkg::RegSourceEast:  src_east_reg  <= cfg_data;
                mpsl_pkg::RegSourceNorth: src_north_reg <= cfg_data;
                mpsl_pkg::RegSourceDepth: src_depth_reg <= cfg_data;
                mpsl_pkg::RegVolumeRate:  rate_reg      <= cfg_data;
                mpsl_pkg::RegPoisson:     nu_reg        <= cfg_data[mpsl_pkg::NuW-1:0];
                mpsl_pkg::RegLookSelect:  look_reg      <= cfg_data[0];
                default:                  ;
            endcase
        end
    end

    mpsl_norm u_norm
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (adv),
        .in_valid     (in_valid),
        .obs_east     (obs_east),
        .obs_north    (obs_north),
        .source_east  (src_east_reg),
        .source_north (src_north_reg),
        .source_depth (src_depth_reg),
        .look_select  (look_reg),
        .out_valid    (n_valid),
        .out_s2       (n_s2),
        .out_nh       (n_nh),
        .out_side     (n_side)
    );

    mpsl_isqrt u_isqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (n_valid),
        .in_s2     (n_s2),
        .in_nh     (n_nh),
        .in_side   (n_side),
        .out_valid (q_valid),
        .out_root  (q_root),
        .out_s2    (q_s2),
        .out_nh    (q_nh),
        .out_side  (q_side)
    );

    assign r3 = mpsl_pkg::R3W'(q_s2) * mpsl_pkg::R3W'(q_root);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            r_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dvsr_reg   <= r3[mpsl_pkg::R3W-1:mpsl_pkg::R3Shift];
            num_reg    <= {q_nh, {mpsl_pkg::FracShift{1'b0}}};
            r_side_reg <= q_side;
        end
    end

    mpsl_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (r_valid_reg),
        .in_num    (num_reg),
        .in_dvsr   (dvsr_reg),
        .in_side   (r_side_reg),
        .out_valid (d_valid),
        .out_quot  (d_quot),
        .out_side  (d_side)
    );

    // (1 - nu) * |rate| * YPI
    assign rmag = rate_reg[31] ? 32'(-rate_reg) : 32'(rate_reg);

    always_ff @(posedge clk)
    begin
        rn_reg <= mpsl_pkg::RnW'(rmag) * (mpsl_pkg::RnW'(17'h10000) - mpsl_pkg::RnW'(nu_reg));
        pa_reg <= 64'(rn_reg[31:0]) * 64'(mpsl_pkg::Ypi);
        pb_reg <= mpsl_pkg::RnW'(rn_reg[mpsl_pkg::RnW-1:32]) * mpsl_pkg::RnW'(mpsl_pkg::Ypi);
        p_reg  <= mpsl_pkg::PW'(pa_reg) + (mpsl_pkg::PW'(pb_reg) << 32);
    end

    assign tsh = mpsl_pkg::TW'(mpsl_pkg::TBase) + mpsl_pkg::TW'({f_side_reg[1].blen, 1'b0});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= '0;
        end
        else if (adv)
        begin
            f_valid_reg <= {f_valid_reg[1:0], d_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pp0_reg       <= 62'(p_reg[31:0]) * 62'(d_quot);
            pp1_reg       <= 62'(p_reg[63:32]) * 62'(d_quot);
            pp2_reg       <= 47'(p_reg[mpsl_pkg::PW-1:64]) * 47'(d_quot);
            f_side_reg[0] <= d_side;
            prod_reg      <= ProdW'(pp0_reg) + (ProdW'(pp1_reg) << 32)
                           + (ProdW'(pp2_reg) << 64);
            f_side_reg[1] <= f_side_reg[0];
            shv_reg       <= ShW'(prod_reg >> tsh);
            f_side_reg[2] <= f_side_reg[1];
        end
    end

    always_comb
    begin
        neg   = rate_reg[31] ^ f_side_reg[2].nneg;
        limit = neg ? ShW'(33'h080000000) : ShW'(33'h07FFFFFFF);
        sat   = shv_reg > limit;
        res   = sat ? limit[31:0] : shv_reg[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= f_valid_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (f_side_reg[2].zero)
            begin
                los_reg <= '0;
                oor_reg <= 1'b1;
            end
            else
            begin
                los_reg <= neg ? 32'(-res) : res;
                oor_reg <= sat;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign los_displacement = los_reg;
    assign out_of_range     = oor_reg;

endmodule
